[hw/rtl/saif_pkg.sv]
// shared types and constants for the source address ignore filter
package saif_pkg;

	// table size and compare width
	localparam int DEPTH      = 16;
	localparam int ADDR_BYTES = 6;
	localparam int ADDR_W     = 48;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W      = (ADDR_BYTES * 8 > ADDR_W) ? ADDR_W : ADDR_BYTES * 8;

	// command codes
	typedef enum logic [1:0] {
		CMD_CHECK  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE       = 2'd0,
		STAT_LISTED     = 2'd1,
		STAT_NOT_LISTED = 2'd2,
		STAT_FULL       = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_WALK = 1'b1
	} state_t;

	// request from the sequencer to the address memory
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [ADDR_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage

[hw/rtl/saif_ram.sv]
// generic single write port memory with registered read data
module saif_ram #(
	parameter int WIDTH   = 48,
	parameter int ENTRIES = 16,
	localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/saif_ctrl.sv]
// sequencer: walks the table, keeps valid bits, builds the result word
module saif_ctrl import saif_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        cmd,
	input  logic [ADDR_W-1:0] addr,
	input  logic [ADDR_W-1:0] rd_data,
	output logic              busy,
	output mem_req_t          mem_req,
	output logic              done,
	output logic [1:0]        status,
	output logic              drop
);

	state_t            state_q, state_d;
	logic [1:0]        cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  idx_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [DEPTH-1:0]  valid_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic              drop_q;

	logic              accept;
	logic              cur_valid;
	logic              match;
	logic              last;
	logic              finish;
	logic              free_any;
	logic [IDX_W-1:0]  free_now;
	logic              set_valid;
	logic              clr_valid;
	status_t           res_status;
	logic              res_drop;

	assign accept    = start && (state_q == S_IDLE);
	assign cur_valid = valid_q[idx_q];
	assign match     = cur_valid && (rd_data[CMP_W-1:0] == addr_q[CMP_W-1:0]);
	assign last      = (idx_q == IDX_W'(DEPTH - 1));
	assign free_any  = free_found_q || !cur_valid;
	assign free_now  = free_found_q ? free_idx_q : idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_WALK;
			end
			S_WALK: begin
				if (match || last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the walk: memory request, result and valid updates
	always_comb begin
		finish         = 1'b0;
		set_valid      = 1'b0;
		clr_valid      = 1'b0;
		res_status     = STAT_DONE;
		res_drop       = 1'b0;
		mem_req.we     = 1'b0;
		mem_req.waddr  = free_now;
		mem_req.wdata  = addr_q;
		mem_req.raddr  = '0;
		case (state_q)
			S_IDLE: begin
				mem_req.raddr = '0;
			end
			S_WALK: begin
				mem_req.raddr = idx_q + IDX_W'(1);
				finish        = match || last;
				if (finish) begin
					case (cmd_t'(cmd_q))
						CMD_CHECK: begin
							res_drop = match;
						end
						CMD_ADD: begin
							if (match) begin
								res_status = STAT_LISTED;
							end else if (free_any) begin
								mem_req.we = 1'b1;
								set_valid  = 1'b1;
							end else begin
								res_status = STAT_FULL;
							end
						end
						CMD_REMOVE: begin
							if (match) clr_valid = 1'b1;
							else res_status = STAT_NOT_LISTED;
						end
						default: res_status = STAT_DONE;
					endcase
				end
			end
			default: mem_req.raddr = '0;
		endcase
	end

	// control state and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			done_q       <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (accept) begin
				free_found_q <= 1'b0;
			end else if (state_q == S_WALK && !cur_valid) begin
				free_found_q <= 1'b1;
			end
			if (set_valid) valid_q[free_now] <= 1'b1;
			if (clr_valid) valid_q[idx_q] <= 1'b0;
		end
	end

	// payload registers for the word in flight and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			addr_q <= addr;
			idx_q  <= '0;
		end else if (state_q == S_WALK) begin
			idx_q <= idx_q + IDX_W'(1);
			if (!free_found_q) free_idx_q <= idx_q;
		end
		if (finish) begin
			status_q <= res_status;
			drop_q   <= res_drop;
		end
	end

	assign busy   = (state_q == S_WALK);
	assign done   = done_q;
	assign status = status_q;
	assign drop   = drop_q;

endmodule

[hw/rtl/source_address_ignore_filter_unit.sv]
// top level: source address ignore table with check, add and remove commands
// one table entry read per cycle while the walk runs from start to done
// one word at a time; busy stays high while the walk runs
// the walk stops at the first matching entry; adds of a new address and misses walk the table
// a new word may start in the cycle its predecessor's result is shown; the receiver cannot stall
// reset clears all valid bits at once, so the table is empty with no clearing pass
module source_address_ignore_filter_unit import saif_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [ADDR_W-1:0] addr,
	output logic              done,
	output logic [1:0]        status,
	output logic              drop
);

	mem_req_t          mem_req;
	logic [ADDR_W-1:0] rd_data;

	// sequencer
	saif_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.addr    (addr),
		.rd_data (rd_data),
		.busy    (busy),
		.mem_req (mem_req),
		.done    (done),
		.status  (status),
		.drop    (drop)
	);

	// stored addresses
	saif_ram #(
		.WIDTH   (ADDR_W),
		.ENTRIES (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

`ifndef SYNTH
	// result strobe lasts a single cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");

	// an accepted word starts a walk
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not start a walk");

	// every result comes out of a walk
	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a walk");

	// a drop hit never reports a table status
	a_drop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && drop) |-> (status == STAT_DONE)) else $error("drop with nonzero status");
`endif

endmodule

[bench/source_address_ignore_filter_unit_test.sv]
// self-checking bench for the source address ignore table: directed table then random traffic
module source_address_ignore_filter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import saif_pkg::*;

	// command code the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         DIRECTED_ROWS = 25;
	localparam int         RANDOM_SEGMENTS = 13;
	localparam int         SEGMENT_WORDS = 125;
	localparam int         CYCLE_LIMIT = 400000;

	// one outcome of a word
	typedef struct packed {
		status_t status;
		logic    drop;
	} verdict_t;

	// one row of the directed table; typed rows carry their own outcome
	typedef struct {
		logic [1:0]        op;
		logic [ADDR_W-1:0] a;
		bit                typed;
		status_t           status;
		logic              drop;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        cmd = CMD_CHECK;
	logic [ADDR_W-1:0] addr = '0;
	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic              drop;

	// typed outcome travels with the word it belongs to
	bit                row_typed = 1'b0;
	status_t           row_status = STAT_DONE;
	logic              row_drop = 1'b0;

	// shadow copy of the ignore table
	logic [ADDR_W-1:0] shadow_addr [DEPTH];
	bit                shadow_valid [DEPTH];

	verdict_t          pending_verdicts [$];
	verdict_t          head_verdict;
	verdict_t          next_verdict;
	stim_row_t         directed_rows [DIRECTED_ROWS];
	logic [ADDR_W-1:0] addr_pool [32];

	int words_sent = 0;
	int verdicts_seen = 0;
	int drops_seen = 0;
	int listed_seen = 0;
	int not_listed_seen = 0;
	int full_seen = 0;
	int fail_count = 0;
	int cycle_count = 0;

	source_address_ignore_filter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.addr   (addr),
		.done   (done),
		.status (status),
		.drop   (drop)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// apply one word to the shadow table and return what the block must report
	function automatic verdict_t apply_filter_cmd(input logic [1:0] op,
			input logic [ADDR_W-1:0] a);
		verdict_t          v;
		int                hit;
		int                free_slot;
		logic [ADDR_W-1:0] mask;
		mask = {ADDR_W{1'b1}} >> (ADDR_W - CMP_W);
		hit = -1;
		free_slot = -1;
		// walk downward so the lowest slot wins
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (shadow_valid[i] && ((shadow_addr[i] & mask) == (a & mask)))
				hit = i;
			if (!shadow_valid[i])
				free_slot = i;
		end
		v.status = STAT_DONE;
		v.drop = 1'b0;
		case (op)
			CMD_CHECK: begin
				v.drop = (hit >= 0);
			end
			CMD_ADD: begin
				if (hit >= 0)
					v.status = STAT_LISTED;
				else if (free_slot < 0)
					v.status = STAT_FULL;
				else begin
					shadow_addr[free_slot] = a;
					shadow_valid[free_slot] = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0)
					shadow_valid[hit] = 1'b0;
				else
					v.status = STAT_NOT_LISTED;
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	// idle length before a word: mostly none or short, now and then long
	function automatic int random_gap(input bit calm);
		int r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// hold a word on the inputs until the block takes it
	task automatic issue_word(input logic [1:0] op, input logic [ADDR_W-1:0] a,
			input bit typed, input status_t st, input logic dr, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		addr <= a;
		row_typed <= typed;
		row_status <= st;
		row_drop <= dr;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	// check results against the oldest outcome, then record newly taken words
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				verdicts_seen++;
				if (pending_verdicts.size() == 0) begin
					$display("%0t: unexpected result, status %0d drop %0d", $time, status, drop);
					fail_count++;
				end else begin
					head_verdict = pending_verdicts.pop_front();
					if (status !== head_verdict.status) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, head_verdict.status, status);
						fail_count++;
					end
					if (drop !== head_verdict.drop) begin
						$display("%0t: drop mismatch, expected %0d actual %0d",
							$time, head_verdict.drop, drop);
						fail_count++;
					end
				end
				if (drop === 1'b1)
					drops_seen++;
				if (status === STAT_LISTED)
					listed_seen++;
				if (status === STAT_NOT_LISTED)
					not_listed_seen++;
				if (status === STAT_FULL)
					full_seen++;
			end
			if (start && !busy) begin
				next_verdict = apply_filter_cmd(cmd, addr);
				if (row_typed)
					next_verdict = '{row_status, row_drop};
				pending_verdicts.push_back(next_verdict);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, pending_verdicts.size());
			$display("source_address_ignore_filter_unit verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int                pool_size;
		bit                calm;
		logic [1:0]        op;
		logic [ADDR_W-1:0] a;
		int                r;
		logic [63:0]       rnd;

		for (int i = 0; i < DEPTH; i++) begin
			shadow_addr[i] = '0;
			shadow_valid[i] = 1'b0;
		end

		// directed table: empty table, extremes, duplicate, remove, then fill to full
		directed_rows[0] = '{CMD_CHECK, 48'h0, 1'b1, STAT_DONE, 1'b0};
		directed_rows[1] = '{CMD_REMOVE, {ADDR_W{1'b1}}, 1'b1, STAT_NOT_LISTED, 1'b0};
		directed_rows[2] = '{CMD_UNUSED, {ADDR_W{1'b1}}, 1'b1, STAT_DONE, 1'b0};
		directed_rows[3] = '{CMD_ADD, 48'h0, 1'b0, STAT_DONE, 1'b0};
		directed_rows[4] = '{CMD_ADD, {ADDR_W{1'b1}}, 1'b0, STAT_DONE, 1'b0};
		directed_rows[5] = '{CMD_ADD, {ADDR_W{1'b1}}, 1'b0, STAT_DONE, 1'b0};
		directed_rows[6] = '{CMD_CHECK, {ADDR_W{1'b1}}, 1'b0, STAT_DONE, 1'b0};
		directed_rows[7] = '{CMD_REMOVE, 48'h0, 1'b0, STAT_DONE, 1'b0};
		directed_rows[8] = '{CMD_CHECK, 48'h0, 1'b0, STAT_DONE, 1'b0};
		for (int k = 0; k < 15; k++)
			directed_rows[9 + k] = '{CMD_ADD, 48'h1 << (3 * k), 1'b0, STAT_DONE, 1'b0};
		directed_rows[24] = '{CMD_ADD, 48'h5555_5555_5555, 1'b1, STAT_FULL, 1'b0};

		// reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_word(directed_rows[i].op, directed_rows[i].a, directed_rows[i].typed,
				directed_rows[i].status, directed_rows[i].drop, random_gap(1'b0));

		// random traffic from a small address pool so hits, duplicates and full occur
		for (int s = 0; s < RANDOM_SEGMENTS; s++) begin
			r = $urandom_range(3);
			pool_size = (r == 0) ? 3 : (r == 1) ? 10 : (r == 2) ? 18 : 30;
			calm = ($urandom_range(3) == 0);
			for (int i = 0; i < pool_size; i++) begin
				rnd = {$urandom, $urandom};
				addr_pool[i] = rnd[ADDR_W-1:0];
			end
			for (int n = 0; n < SEGMENT_WORDS; n++) begin
				r = $urandom_range(99);
				op = (r < 38) ? CMD_CHECK : (r < 70) ? CMD_ADD : (r < 95) ? CMD_REMOVE : CMD_UNUSED;
				rnd = {$urandom, $urandom};
				a = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(pool_size - 1)]
					: rnd[ADDR_W-1:0];
				issue_word(op, a, 1'b0, STAT_DONE, 1'b0, random_gap(calm));
			end
		end

		// drain
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		$display("covered %0d words with %0d results: %0d drop hits, %0d duplicate adds,",
			words_sent, verdicts_seen, drops_seen, listed_seen);
		$display("%0d full-table adds, %0d absent removes, %0d failures",
			full_seen, not_listed_seen, fail_count);
		if (fail_count == 0)
			$display("source_address_ignore_filter_unit verification clean");
		else
			$display("source_address_ignore_filter_unit verification failed");
		$finish;
	end

endmodule
